>>> rtl/core/tcbsa_pkg.sv
// Shared types, codes and constants for the three-class batch arbiter.
// No dependencies; every other file in rtl/core but tcbsa_ram imports this package.
`default_nettype none

package tcbsa_pkg;

    // Fixed field widths of the channels
    localparam int CMD_W    = 1;
    localparam int CLASS_W  = 2;
    localparam int TAG_W    = 8;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ADD      = 1'b0;
    localparam logic [CMD_W-1:0] CMD_DISPATCH = 1'b1;

    // Request classes; CLS_NONE marks "no class chosen"
    typedef enum logic [CLASS_W-1:0] {
        CLS_READ  = 2'd0,
        CLS_SYNC  = 2'd1,
        CLS_ASYNC = 2'd2,
        CLS_NONE  = 2'd3
    } class_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        RS_DONE  = 2'd0,
        RS_DROP  = 2'd1,
        RS_EMPTY = 2'd2
    } status_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_READ_BATCH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_BATCH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ASYNC_BATCH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_LINE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ASYNC_LINE  = 3'd4;

    // Configuration reset values
    localparam logic [CFG_W-1:0] RST_READ_BATCH  = 16'd8;
    localparam logic [CFG_W-1:0] RST_SYNC_BATCH  = 16'd4;
    localparam logic [CFG_W-1:0] RST_ASYNC_BATCH = 16'd4;
    localparam logic [CFG_W-1:0] RST_SYNC_LINE   = 16'd1;
    localparam logic [CFG_W-1:0] RST_ASYNC_LINE  = 16'd5;

    // Saturation point of batch and starvation counters
    localparam logic [CFG_W-1:0] CNT_MAX = 16'hFFFF;

    // Configuration register file as seen by the scheduler
    typedef struct packed {
        logic [CFG_W-1:0] read_batch;
        logic [CFG_W-1:0] sync_batch;
        logic [CFG_W-1:0] async_batch;
        logic [CFG_W-1:0] sync_line;
        logic [CFG_W-1:0] async_line;
    } cfg_t;

    // Classified request handed from front end to back end
    typedef struct packed {
        logic               is_dispatch;
        logic               cls_ok;
        logic [CLASS_W-1:0] cls;
        logic [TAG_W-1:0]   tag;
    } cmd_t;

    // Saturating increment
    function automatic logic [CFG_W-1:0] sat_inc(input logic [CFG_W-1:0] v, input logic by);
        return (by && (v != CNT_MAX)) ? v + 16'd1 : v;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/tcbsa_cmd_if.sv
// Request channel interface: valid/ready plus command, class and tag.
// Depends on tcbsa_pkg for field widths.
`default_nettype none

interface tcbsa_cmd_if;
    import tcbsa_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [CLASS_W-1:0] request_class;
    logic [TAG_W-1:0]   request_tag;

    modport source (output valid, command, request_class, request_tag, input ready);
    modport sink   (input valid, command, request_class, request_tag, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tcbsa_rsp_if.sv
// Result channel interface: valid/ready plus status, tag and class.
// Depends on tcbsa_pkg for field widths.
`default_nettype none

interface tcbsa_rsp_if;
    import tcbsa_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    out_tag;
    logic [CLASS_W-1:0]  out_class;

    modport source (output valid, status, out_tag, out_class, input ready);
    modport sink   (input valid, status, out_tag, out_class, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tcbsa_cfg_if.sv
// Configuration write channel interface: valid/ready, register index, data.
// Depends on tcbsa_pkg for field widths.
`default_nettype none

interface tcbsa_cfg_if;
    import tcbsa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tcbsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tcbsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 48,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/tcbsa_front.sv
// Front end: accepts requests, classifies them and holds them in a
// two-entry queue for the back end. Depends on tcbsa_pkg, tcbsa_cmd_if.
`default_nettype none

module tcbsa_front (
    input  logic              clk,
    input  logic              rst_n,
    tcbsa_cmd_if.sink         cmd,
    output logic              q_valid,
    output tcbsa_pkg::cmd_t   q_data,
    input  logic              q_pop
);
    import tcbsa_pkg::*;

    cmd_t       ent_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       push;
    cmd_t       cls_cmd;

    // Classify the incoming request
    always_comb
    begin
        cls_cmd.is_dispatch = (cmd.command == CMD_DISPATCH);
        cls_cmd.cls_ok      = (cmd.request_class != CLS_NONE);
        cls_cmd.cls         = cmd.request_class;
        cls_cmd.tag         = cmd.request_tag;
    end

    assign cmd.ready = (fill_reg != 2'd2);
    assign push      = cmd.valid && cmd.ready;
    assign q_valid   = (fill_reg != 2'd0);
    assign q_data    = ent_reg[rd_ptr_reg];

    // Fill level
    always_comb
    begin
        fill_next = fill_reg;
        if (push && !q_pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_next;
        end
    end

    // Queue payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= cls_cmd;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/tcbsa_back.sv
// Back end: per-class FIFOs in one RAM, class selection with batching and
// write starvation override, result register. Depends on tcbsa_pkg,
// tcbsa_rsp_if and tcbsa_ram.
`default_nettype none

module tcbsa_back #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  tcbsa_pkg::cfg_t cfg_regs,
    input  logic            q_valid,
    input  tcbsa_pkg::cmd_t q_data,
    output logic            q_pop,
    tcbsa_rsp_if.source     rsp
);
    import tcbsa_pkg::*;

    localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int RAM_DEPTH = 3 * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);
    localparam logic [PTR_W-1:0]  PTR_LAST   = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL   = CNT_W'(QUEUE_DEPTH);
    localparam logic [ADDR_W-1:0] BASE_SYNC  = ADDR_W'(QUEUE_DEPTH);
    localparam logic [ADDR_W-1:0] BASE_ASYNC = ADDR_W'(2 * QUEUE_DEPTH);

    typedef enum logic {
        ST_RUN,
        ST_FETCH
    } state_t;

    state_t             st_reg, st_next;
    logic [PTR_W-1:0]   head_reg [3];
    logic [PTR_W-1:0]   head_next [3];
    logic [PTR_W-1:0]   tail_reg [3];
    logic [PTR_W-1:0]   tail_next [3];
    logic [CNT_W-1:0]   count_reg [3];
    logic [CNT_W-1:0]   count_next [3];
    class_t             cur_reg, cur_next;
    logic [CFG_W-1:0]   batch_reg, batch_next;
    logic [CFG_W-1:0]   starve_reg [2];
    logic [CFG_W-1:0]   starve_next [2];
    class_t             fetch_cls_reg, fetch_cls_next;
    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg, out_status_next;
    logic [TAG_W-1:0]   out_tag_reg, out_tag_next;
    class_t             out_class_reg, out_class_next;

    logic [2:0]         ne;
    logic               cur_ne;
    logic [CFG_W-1:0]   cur_lim;
    logic               cur_ok;
    logic               starve_sync;
    logic               starve_async;
    class_t             pick;
    logic [1:0]         srv_idx;
    logic [1:0]         add_idx;
    logic               out_free;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [TAG_BITS-1:0] ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [TAG_BITS-1:0] ram_rdata;

    function automatic logic [ADDR_W-1:0] base_of(input logic [1:0] c);
        logic [ADDR_W-1:0] b;
        unique case (c)
            CLS_SYNC:  b = BASE_SYNC;
            CLS_ASYNC: b = BASE_ASYNC;
            default:   b = '0;
        endcase
        return b;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    tcbsa_ram #(
        .WIDTH (TAG_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Class selection for a dispatch
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            ne[c] = (count_reg[c] != '0);
        end
        unique case (cur_reg)
            CLS_READ:  begin cur_ne = ne[0]; cur_lim = cfg_regs.read_batch;  end
            CLS_SYNC:  begin cur_ne = ne[1]; cur_lim = cfg_regs.sync_batch;  end
            CLS_ASYNC: begin cur_ne = ne[2]; cur_lim = cfg_regs.async_batch; end
            default:   begin cur_ne = 1'b0;  cur_lim = '0;                   end
        endcase
        cur_ok       = cur_ne && (batch_reg < cur_lim);
        starve_sync  = (starve_reg[0] > cfg_regs.sync_line) && ne[1];
        starve_async = (starve_reg[1] > cfg_regs.async_line) && ne[2];
        // Async starvation beats sync starvation, which beats reads
        priority if (starve_async)
        begin
            pick = CLS_ASYNC;
        end
        else if (ne[0] && !starve_sync)
        begin
            pick = CLS_READ;
        end
        else if (ne[1])
        begin
            pick = CLS_SYNC;
        end
        else if (ne[2])
        begin
            pick = CLS_ASYNC;
        end
        else
        begin
            pick = CLS_NONE;
        end
        srv_idx = cur_ok ? cur_reg : pick;
        add_idx = q_data.cls_ok ? q_data.cls : 2'd0;
    end

    assign out_free = !out_valid_reg || rsp.ready;

    // Execution of one request
    always_comb
    begin
        st_next         = st_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        cur_next        = cur_reg;
        batch_next      = batch_reg;
        starve_next     = starve_reg;
        fetch_cls_next  = fetch_cls_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_tag_next    = out_tag_reg;
        out_class_next  = out_class_reg;
        q_pop           = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = TAG_BITS'(q_data.tag);
        ram_re          = 1'b0;
        ram_raddr       = '0;

        unique case (st_reg)
            ST_FETCH:
            begin
                // Tag read is back from the store
                out_valid_next  = 1'b1;
                out_status_next = RS_DONE;
                out_tag_next    = TAG_W'(ram_rdata);
                out_class_next  = fetch_cls_reg;
                st_next         = ST_RUN;
            end
            ST_RUN:
            begin
                if (q_valid && out_free)
                begin
                    q_pop          = 1'b1;
                    out_tag_next   = '0;
                    out_class_next = CLS_READ;
                    if (!q_data.is_dispatch)
                    begin
                        // Add: append tag unless class invalid or FIFO full
                        out_valid_next = 1'b1;
                        if (!q_data.cls_ok || (count_reg[add_idx] == CNT_FULL))
                        begin
                            out_status_next = RS_DROP;
                        end
                        else
                        begin
                            out_status_next    = RS_DONE;
                            ram_we             = 1'b1;
                            ram_waddr          = base_of(add_idx) + ADDR_W'(tail_reg[add_idx]);
                            tail_next[add_idx] = ptr_inc(tail_reg[add_idx]);
                            count_next[add_idx] = count_reg[add_idx] + CNT_W'(1);
                        end
                    end
                    else if (!cur_ok && (pick == CLS_NONE))
                    begin
                        // Nothing queued anywhere
                        out_valid_next  = 1'b1;
                        out_status_next = RS_EMPTY;
                        cur_next        = CLS_NONE;
                    end
                    else
                    begin
                        if (cur_ok)
                        begin
                            batch_next = sat_inc(batch_reg, 1'b1);
                        end
                        else
                        begin
                            // New batch: first request counts as one
                            cur_next   = pick;
                            batch_next = 16'd1;
                            unique case (pick)
                                CLS_READ:
                                begin
                                    starve_next[0] = sat_inc(starve_reg[0], ne[1]);
                                    starve_next[1] = sat_inc(starve_reg[1], ne[2]);
                                end
                                CLS_SYNC:
                                begin
                                    starve_next[0] = '0;
                                    starve_next[1] = sat_inc(starve_reg[1], ne[2]);
                                end
                                default:
                                begin
                                    starve_next[0] = sat_inc(starve_reg[0], ne[1]);
                                    starve_next[1] = '0;
                                end
                            endcase
                        end
                        ram_re              = 1'b1;
                        ram_raddr           = base_of(srv_idx) + ADDR_W'(head_reg[srv_idx]);
                        head_next[srv_idx]  = ptr_inc(head_reg[srv_idx]);
                        count_next[srv_idx] = count_reg[srv_idx] - CNT_W'(1);
                        fetch_cls_next      = class_t'(srv_idx);
                        st_next             = ST_FETCH;
                    end
                end
            end
            default:
            begin
                st_next = ST_RUN;
            end
        endcase
    end

    // State and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= ST_RUN;
            head_reg       <= '{default: '0};
            tail_reg       <= '{default: '0};
            count_reg      <= '{default: '0};
            cur_reg        <= CLS_NONE;
            batch_reg      <= '0;
            starve_reg     <= '{default: '0};
            fetch_cls_reg  <= CLS_READ;
            out_valid_reg  <= 1'b0;
            out_status_reg <= RS_DONE;
            out_tag_reg    <= '0;
            out_class_reg  <= CLS_READ;
        end
        else
        begin
            st_reg         <= st_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            cur_reg        <= cur_next;
            batch_reg      <= batch_next;
            starve_reg     <= starve_next;
            fetch_cls_reg  <= fetch_cls_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_tag_reg    <= out_tag_next;
            out_class_reg  <= out_class_next;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.out_tag   = out_tag_reg;
    assign rsp.out_class = out_class_reg;

endmodule

`default_nettype wire

>>> rtl/core/three_class_batch_starvation_arbiter.sv
// Three-class batch arbiter with write starvation override: configuration
// registers and the front/back split. Depends on tcbsa_pkg, the channel
// interfaces, tcbsa_front and tcbsa_back.
//
// Use: requests enter on cmd (valid/ready). An add appends request_tag to
// the FIFO of request_class; a dispatch pops one tag from the class being
// served, choosing a new class when the batch ends or the FIFO runs dry.
// Every request yields exactly one result on rsp (valid/ready): status,
// out_tag and out_class. Configuration registers are written on cfg
// (valid/ready, index 0..4); cfg is always ready and writes to unknown
// indexes are ignored. Write configuration only while no request is open.
// Path: an accepted add goes from the two-entry queue to the result
// register; a dispatch first waits in ST_FETCH, as the tag store has a
// registered read port. Throughput: the back end retires one add per
// cycle while rsp is ready, but no request while in ST_FETCH; the
// two-entry queue decouples cmd from it.
// Reset: all FIFOs empty, no class chosen, counters zero, registers at
// defaults (batches 8/4/4, starvation lines 1/5).
// Stall: when rsp is not taken the result register holds, the back end
// stops, the queue fills and cmd.ready drops once it holds two requests.
`default_nettype none

module three_class_batch_starvation_arbiter #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    tcbsa_cmd_if.sink   cmd,
    tcbsa_rsp_if.source rsp,
    tcbsa_cfg_if.sink   cfg
);
    import tcbsa_pkg::*;

    cfg_t cfg_reg;
    logic q_valid;
    cmd_t q_data;
    logic q_pop;

    assign cfg.ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.read_batch  <= RST_READ_BATCH;
            cfg_reg.sync_batch  <= RST_SYNC_BATCH;
            cfg_reg.async_batch <= RST_ASYNC_BATCH;
            cfg_reg.sync_line   <= RST_SYNC_LINE;
            cfg_reg.async_line  <= RST_ASYNC_LINE;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_READ_BATCH:  cfg_reg.read_batch  <= cfg.data;
                CFG_SYNC_BATCH:  cfg_reg.sync_batch  <= cfg.data;
                CFG_ASYNC_BATCH: cfg_reg.async_batch <= cfg.data;
                CFG_SYNC_LINE:   cfg_reg.sync_line   <= cfg.data;
                CFG_ASYNC_LINE:  cfg_reg.async_line  <= cfg.data;
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    tcbsa_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop)
    );

    tcbsa_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_regs (cfg_reg),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .rsp      (rsp)
    );

endmodule

`default_nettype wire

>>> tb/sv/tb_three_class_batch_starvation_arbiter.sv
// Self-checking testbench for the three-class batch starvation arbiter.
// Depends on tcbsa_pkg, the cmd/rsp/cfg channel interfaces and the RTL top;
// a scoreboard class predicts every result and checks it in order.

module tb_three_class_batch_starvation_arbiter;
    import tcbsa_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDLE_LIMIT  = 2000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 85;
    localparam int TAIL_PAIRS  = 8;

    // One predicted result
    typedef struct {
        status_t          status;
        logic [TAG_W-1:0] tag;
        class_t           cls;
    } request_outcome_t;

    // Predicts the dispatch order and holds the outcomes still to arrive
    class dispatch_order_model;
        logic [TAG_W-1:0] tag_fifo[3][$];
        logic [CFG_W-1:0] batch_limit[3];
        logic [CFG_W-1:0] starve_line[2];
        logic [CFG_W-1:0] starve_cnt[2];
        logic [CFG_W-1:0] batch_cnt;
        class_t           serving;
        request_outcome_t outcomes[$];
        int               failures;

        function new();
            batch_limit = '{RST_READ_BATCH, RST_SYNC_BATCH, RST_ASYNC_BATCH};
            starve_line = '{RST_SYNC_LINE, RST_ASYNC_LINE};
            starve_cnt  = '{16'd0, 16'd0};
            batch_cnt   = '0;
            serving     = CLS_NONE;
            failures    = 0;
        endfunction

        function logic [CFG_W-1:0] bump(logic [CFG_W-1:0] v, bit by);
            return (by && v != CNT_MAX) ? v + 16'd1 : v;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_READ_BATCH:  batch_limit[CLS_READ]  = val;
                CFG_SYNC_BATCH:  batch_limit[CLS_SYNC]  = val;
                CFG_ASYNC_BATCH: batch_limit[CLS_ASYNC] = val;
                CFG_SYNC_LINE:   starve_line[0] = val;
                CFG_ASYNC_LINE:  starve_line[1] = val;
                default: ;
            endcase
        endfunction

        function int queued_total();
            return tag_fifo[0].size() + tag_fifo[1].size() + tag_fifo[2].size();
        endfunction

        function int outstanding();
            return outcomes.size();
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= 10)
                $display("MISMATCH: %s", msg);
        endfunction

        // Accepted request: update the queues and schedule state
        function void take_request(logic cmd, logic [CLASS_W-1:0] cls,
                                   logic [TAG_W-1:0] tag);
            request_outcome_t r;
            bit               has[3];
            bit               force_sync;
            bit               force_async;
            class_t           pick;
            r.status = RS_DONE;
            r.tag    = '0;
            r.cls    = CLS_READ;
            if (cmd == CMD_ADD)
            begin
                if (cls == CLS_NONE || tag_fifo[cls].size() >= QUEUE_DEPTH)
                    r.status = RS_DROP;
                else
                    tag_fifo[cls].push_back(tag);
            end
            else
            begin
                for (int c = 0; c < 3; c++)
                    has[c] = tag_fifo[c].size() != 0;
                // batch ends at its limit or when its queue runs dry
                if (serving != CLS_NONE &&
                    (batch_cnt >= batch_limit[serving] || !has[serving]))
                    serving = CLS_NONE;
                if (serving == CLS_NONE)
                begin
                    force_sync  = starve_cnt[0] > starve_line[0] && has[CLS_SYNC];
                    force_async = starve_cnt[1] > starve_line[1] && has[CLS_ASYNC];
                    if (has[CLS_READ])
                        pick = force_async ? CLS_ASYNC : (force_sync ? CLS_SYNC : CLS_READ);
                    else if (has[CLS_SYNC])
                        pick = force_async ? CLS_ASYNC : CLS_SYNC;
                    else
                        pick = has[CLS_ASYNC] ? CLS_ASYNC : CLS_NONE;
                    if (pick != CLS_NONE)
                    begin
                        serving   = pick;
                        batch_cnt = '0;
                        starve_cnt[0] = (pick == CLS_SYNC) ? 16'd0 :
                                        bump(starve_cnt[0], has[CLS_SYNC]);
                        starve_cnt[1] = (pick == CLS_ASYNC) ? 16'd0 :
                                        bump(starve_cnt[1], has[CLS_ASYNC]);
                    end
                end
                if (serving == CLS_NONE)
                    r.status = RS_EMPTY;
                else
                begin
                    r.tag     = tag_fifo[serving].pop_front();
                    r.cls     = serving;
                    batch_cnt = bump(batch_cnt, 1'b1);
                end
            end
            outcomes.push_back(r);
        endfunction

        // Accepted result: compare against the oldest prediction
        function void check_result(logic [STATUS_W-1:0] st, logic [TAG_W-1:0] tg,
                                   logic [CLASS_W-1:0] cl);
            request_outcome_t want;
            if (outcomes.size() == 0)
            begin
                note_failure($sformatf(
                    "result with nothing outstanding: status %0d tag %02h class %0d",
                    st, tg, cl));
                return;
            end
            want = outcomes.pop_front();
            if (st !== want.status || tg !== want.tag || cl !== want.cls)
                note_failure($sformatf(
                    {"expected status %0d tag %02h class %0d, ",
                     "got status %0d tag %02h class %0d"},
                    want.status, want.tag, want.cls, st, tg, cl));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   quiet;
    int   burst_left;
    int   idle_cycles;
    int   stall_left;
    int   ready_left;

    dispatch_order_model model;

    tcbsa_cmd_if cmd_if ();
    tcbsa_rsp_if rsp_if ();
    tcbsa_cfg_if cfg_if ();

    three_class_batch_starvation_arbiter u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    always #5 clk = ~clk;

    // Result side: check accepted results, stall in runs of random length
    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
            model.check_result(rsp_if.status, rsp_if.out_tag, rsp_if.out_class);
        if (quiet)
            rsp_if.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            rsp_if.ready <= 1'b0;
        end
        else
        begin
            rsp_if.ready <= 1'b1;
            if (ready_left > 0)
                ready_left--;
            else
            begin
                ready_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(0, 24);
                stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(1, 4);
            end
        end
    end

    // Watchdog: too long without any handshake ends the run
    always @(posedge clk)
    begin
        if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("three_class_batch_starvation_arbiter verification failed");
            $finish;
        end
    end

    // Issue one request; bursts of back-to-back requests with random gaps
    task automatic send_request(input logic c, input logic [CLASS_W-1:0] k,
                                input logic [TAG_W-1:0] t);
        int gap;
        cmd_if.valid         <= 1'b1;
        cmd_if.command       <= c;
        cmd_if.request_class <= k;
        cmd_if.request_tag   <= t;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        model.take_request(c, k, t);
        if (!quiet)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                   : $urandom_range(1, 5);
                burst_left = $urandom_range(0, 40);
                cmd_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stop sending and hold until every outstanding result is back
    task automatic wait_idle();
        if (cmd_if.valid)
            cmd_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (model.outstanding() != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        model.set_register(idx, val);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [CFG_W-1:0] pick_value(int lo);
        case ($urandom_range(0, 9))
            0:       return CNT_MAX;
            1:       return CFG_W'(lo);
            default: return CFG_W'($urandom_range(lo, 6));
        endcase
    endfunction

    initial
    begin
        int add_pct;
        model = new();
        quiet       = 1'b0;
        burst_left  = 0;
        idle_cycles = 0;
        stall_left  = 0;
        ready_left  = 0;
        rst_n                = 1'b0;
        cmd_if.valid         = 1'b0;
        cmd_if.command       = CMD_ADD;
        cmd_if.request_class = CLS_READ;
        cmd_if.request_tag   = '0;
        rsp_if.ready         = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = CFG_READ_BATCH;
        cfg_if.data          = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty dispatch, bad class, tag extremes, every class
        send_request(CMD_DISPATCH, CLS_READ, 8'h00);
        send_request(CMD_ADD, CLS_NONE, 8'hFF);
        send_request(CMD_ADD, CLS_READ, 8'h00);
        send_request(CMD_ADD, CLS_READ, 8'hFF);
        send_request(CMD_ADD, CLS_SYNC, 8'h55);
        send_request(CMD_ADD, CLS_ASYNC, 8'hAA);
        send_request(CMD_ADD, CLS_READ, 8'h80);
        send_request(CMD_DISPATCH, CLS_SYNC, 8'h3C);
        send_request(CMD_DISPATCH, CLS_ASYNC, 8'hC3);

        // Directed: read batch limit dropped below the running count
        wait_idle();
        write_register(CFG_READ_BATCH, 16'd1);
        send_request(CMD_DISPATCH, CLS_NONE, 8'h0F);

        // Directed: zero batch limit, then drain to empty
        wait_idle();
        write_register(CFG_READ_BATCH, 16'd0);
        send_request(CMD_ADD, CLS_READ, 8'h01);
        send_request(CMD_ADD, CLS_READ, 8'h02);
        repeat (5) send_request(CMD_DISPATCH, CLS_READ, 8'hF0);

        // Random phases, each under its own register setting
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            case (phase)
                0:
                begin
                    write_register(CFG_READ_BATCH, 16'd1);
                    write_register(CFG_SYNC_BATCH, 16'd1);
                    write_register(CFG_ASYNC_BATCH, 16'd1);
                    write_register(CFG_SYNC_LINE, 16'd0);
                    write_register(CFG_ASYNC_LINE, 16'd1);
                end
                1:
                begin
                    write_register(CFG_READ_BATCH, CNT_MAX);
                    write_register(CFG_SYNC_BATCH, CNT_MAX);
                    write_register(CFG_ASYNC_BATCH, CNT_MAX);
                    write_register(CFG_SYNC_LINE, CNT_MAX);
                    write_register(CFG_ASYNC_LINE, CNT_MAX);
                end
                2:
                begin
                    write_register(CFG_READ_BATCH, RST_READ_BATCH);
                    write_register(CFG_SYNC_BATCH, RST_SYNC_BATCH);
                    write_register(CFG_ASYNC_BATCH, RST_ASYNC_BATCH);
                    write_register(CFG_SYNC_LINE, RST_SYNC_LINE);
                    write_register(CFG_ASYNC_LINE, RST_ASYNC_LINE);
                end
                default:
                begin
                    write_register(CFG_READ_BATCH, pick_value(1));
                    write_register(CFG_SYNC_BATCH, pick_value(1));
                    write_register(CFG_ASYNC_BATCH, pick_value(1));
                    write_register(CFG_SYNC_LINE, pick_value(0));
                    write_register(CFG_ASYNC_LINE, pick_value(1));
                end
            endcase
            add_pct = 25 * $urandom_range(1, 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                send_request(($urandom_range(0, 99) < add_pct) ? CMD_ADD : CMD_DISPATCH,
                             ($urandom_range(0, 19) == 0) ? CLASS_W'(CLS_NONE)
                                                           : CLASS_W'($urandom_range(0, 2)),
                             TAG_W'($urandom_range(0, 255)));
                // occasional hold until the block has answered everything
                if ($urandom_range(0, 49) == 0)
                    wait_idle();
            end
        end

        // Read batches of one while both write queues wait; lines at
        // maximum so the writes are passed over and never forced
        wait_idle();
        quiet = 1'b1;
        while (model.queued_total() > 0)
            send_request(CMD_DISPATCH, CLASS_W'($urandom_range(0, 3)),
                         TAG_W'($urandom_range(0, 255)));
        wait_idle();
        write_register(CFG_READ_BATCH, 16'd1);
        write_register(CFG_SYNC_LINE, CNT_MAX);
        write_register(CFG_ASYNC_LINE, CNT_MAX);
        send_request(CMD_ADD, CLS_SYNC, 8'h11);
        send_request(CMD_ADD, CLS_ASYNC, 8'h22);
        repeat (TAIL_PAIRS)
        begin
            send_request(CMD_ADD, CLS_READ, TAG_W'($urandom_range(0, 255)));
            send_request(CMD_DISPATCH, CLS_READ, TAG_W'($urandom_range(0, 255)));
        end

        // Low lines: both writes now forced, async first
        wait_idle();
        write_register(CFG_SYNC_LINE, 16'd1);
        write_register(CFG_ASYNC_LINE, 16'd1);
        repeat (4)
        begin
            send_request(CMD_ADD, CLS_READ, TAG_W'($urandom_range(0, 255)));
            send_request(CMD_DISPATCH, CLS_READ, TAG_W'($urandom_range(0, 255)));
        end
        quiet = 1'b0;

        // Drain and report
        wait_idle();
        repeat (10) @(posedge clk);
        if (model.failures == 0 && model.outstanding() == 0)
            $display("three_class_batch_starvation_arbiter verification clean");
        else
            $display("three_class_batch_starvation_arbiter verification failed");
        $finish;
    end

endmodule
